### sv/ascf_pkg.sv
`timescale 1ns / 1ps

package ascf_pkg;

	localparam int MAX_PARAM_BYTES = 31;
	localparam int KEPT_W = $clog2(MAX_PARAM_BYTES + 1);
	localparam int FIELD_W = 7;
	localparam logic [FIELD_W-1:0] FIELD_MAX = 7'd127;

	localparam logic [7:0] CH_ESC = 8'h1B;
	localparam logic [7:0] CH_LBRACKET = 8'h5B;
	localparam logic [7:0] CH_M = 8'h6D;
	localparam logic [7:0] CH_SEMI = 8'h3B;
	localparam logic [7:0] CH_ZERO = 8'h30;
	localparam logic [7:0] CH_NINE = 8'h39;

	localparam logic [FIELD_W-1:0] SGR_RESET = 7'd0;
	localparam logic [FIELD_W-1:0] SGR_BOLD = 7'd1;
	localparam logic [FIELD_W-1:0] SGR_FG_LO = 7'd30;
	localparam logic [FIELD_W-1:0] SGR_FG_HI = 7'd37;
	localparam logic [FIELD_W-1:0] SGR_FG_DEF = 7'd39;
	localparam logic [FIELD_W-1:0] SGR_BR_LO = 7'd90;
	localparam logic [FIELD_W-1:0] SGR_BR_HI = 7'd97;

	localparam logic [3:0] COLOR_GREY = 4'd7;
	localparam logic [3:0] COLOR_DARK_GREY = 4'd8;

	localparam logic KIND_CHAR = 1'b0;
	localparam logic KIND_COLOR = 1'b1;

	typedef struct packed {
		logic bold;
		logic [3:0] color;
		logic color_set;
	} sgr_stage_t;

	typedef struct packed {
		logic valid;
		logic kind;
		logic [7:0] char_out;
		logic [3:0] color;
	} ascf_res_t;

	// ansi color order to vga color order
	function automatic logic [2:0] base_color(input logic [2:0] idx);
		logic [2:0] c;
		case (idx)
			3'd0: c = 3'd0;
			3'd1: c = 3'd4;
			3'd2: c = 3'd2;
			3'd3: c = 3'd6;
			3'd4: c = 3'd1;
			3'd5: c = 3'd5;
			3'd6: c = 3'd3;
			3'd7: c = 3'd7;
			default: c = 3'd0;
		endcase
		return c;
	endfunction

	function automatic sgr_stage_t apply_code(input logic [FIELD_W-1:0] code,
			input sgr_stage_t st);
		sgr_stage_t r;
		logic [FIELD_W-1:0] off;
		r = st;
		off = '0;
		if (code == SGR_RESET) begin
			r.bold = 1'b0;
			r.color = COLOR_GREY;
			r.color_set = 1'b1;
		end else if (code == SGR_BOLD) begin
			r.bold = 1'b1;
		end else if (code >= SGR_FG_LO && code <= SGR_FG_HI) begin
			off = code - SGR_FG_LO;
			r.color = {st.bold, base_color(off[2:0])};
			r.color_set = 1'b1;
		end else if (code == SGR_FG_DEF) begin
			r.color = st.bold ? COLOR_DARK_GREY : COLOR_GREY;
			r.color_set = 1'b1;
		end else if (code >= SGR_BR_LO && code <= SGR_BR_HI) begin
			off = code - SGR_BR_LO;
			r.color = {1'b1, base_color(off[2:0])};
			r.color_set = 1'b1;
		end
		return r;
	endfunction

endpackage

### sv/ansi_sgr_color_filter_unit.sv
`timescale 1ns / 1ps
// result path: an input byte passes the input register, then the result register, before its result shows on m_tvalid
// throughput: one byte per cycle, sustained while the output side keeps up
// bytes that cause no result (escape and parameter bytes) still pass the input stage and wait for a free output slot
// reset: arst_n low clears both pipeline stages, parser goes to normal mode,
// bold off, current color light grey (7)

module ansi_sgr_color_filter_unit (
	input  logic clk,
	input  logic arst_n,
	input  logic s_tvalid,
	output logic s_tready,
	input  logic [7:0] s_tdata,   // [7:0] byte_in
	output logic m_tvalid,
	input  logic m_tready,
	output logic [15:0] m_tdata,  // [7:0] char_out, [11:8] color, [15:12] zero
	output logic [0:0] m_tuser    // [0] kind
);

	logic valid_s1;
	logic [7:0] byte_s1;
	logic out_free;
	logic advance;
	ascf_pkg::ascf_res_t res;

	assign advance = valid_s1 && out_free;
	assign s_tready = !valid_s1 || advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_tready) begin
			valid_s1 <= s_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (s_tready && s_tvalid) begin
			byte_s1 <= s_tdata;
		end
	end

	ascf_parser u_parser (
		.clk(clk),
		.arst_n(arst_n),
		.en(advance),
		.byte_in(byte_s1),
		.res(res)
	);

	ascf_out_reg u_out (
		.clk(clk),
		.arst_n(arst_n),
		.load(advance),
		.res(res),
		.free(out_free),
		.m_tvalid(m_tvalid),
		.m_tready(m_tready),
		.m_tdata(m_tdata),
		.m_tuser(m_tuser)
	);

	// a color update never carries a character
	a_color_no_char: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && (m_tuser[0] == ascf_pkg::KIND_COLOR) |-> m_tdata[7:0] == 8'h00)
		else $error("color result with nonzero char_out");

	// input stalls only when the input stage is full and the output is blocked
	a_stall_cause: assert property (@(posedge clk) disable iff (!arst_n)
		!s_tready |-> valid_s1 && m_tvalid && !m_tready)
		else $error("input stalled without a blocked output");

	// a byte held in the input stage while the output is empty and no new byte arrives moves on next cycle
	a_s1_moves: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s1 && !m_tvalid && !s_tvalid |=> !valid_s1)
		else $error("input stage did not advance into an empty output");

endmodule

### sv/ascf_parser.sv
`timescale 1ns / 1ps

module ascf_parser (
	input  logic clk,
	input  logic arst_n,
	input  logic en,
	input  logic [7:0] byte_in,
	output ascf_pkg::ascf_res_t res
);

	typedef enum logic [1:0] {
		MODE_NORMAL = 2'd0,
		MODE_ESC    = 2'd1,
		MODE_CSI    = 2'd2
	} mode_t;

	mode_t mode_q, mode_d;
	logic [ascf_pkg::FIELD_W-1:0] field_q, field_d;
	logic has_digit_q, has_digit_d;
	logic [ascf_pkg::KEPT_W-1:0] kept_q, kept_d;
	ascf_pkg::sgr_stage_t staged_q, staged_d;
	logic cbold_q, cbold_d;
	logic [3:0] ccolor_q, ccolor_d;

	logic is_digit;
	logic [3:0] digit_val;
	logic [10:0] acc;
	ascf_pkg::sgr_stage_t semi_stage;
	ascf_pkg::sgr_stage_t final_stage;
	logic [ascf_pkg::FIELD_W-1:0] final_code;
	logic final_apply;

	assign is_digit = (byte_in >= ascf_pkg::CH_ZERO) && (byte_in <= ascf_pkg::CH_NINE);
	assign digit_val = 4'(byte_in - ascf_pkg::CH_ZERO);
	assign acc = 11'(field_q) * 11'd10 + 11'(digit_val);
	assign semi_stage = ascf_pkg::apply_code(field_q, staged_q);

	// empty list acts as code 0, empty trailing field is ignored
	assign final_apply = (kept_q == '0) || has_digit_q;
	assign final_code = (kept_q == '0) ? ascf_pkg::SGR_RESET : field_q;
	assign final_stage = final_apply ? ascf_pkg::apply_code(final_code, staged_q) : staged_q;

	always_comb begin
		mode_d = mode_q;
		field_d = field_q;
		has_digit_d = has_digit_q;
		kept_d = kept_q;
		staged_d = staged_q;
		cbold_d = cbold_q;
		ccolor_d = ccolor_q;
		res.valid = 1'b0;
		res.kind = ascf_pkg::KIND_CHAR;
		res.char_out = byte_in;
		res.color = ccolor_q;
		case (mode_q)
			MODE_ESC: begin
				if (byte_in == ascf_pkg::CH_LBRACKET) begin
					mode_d = MODE_CSI;
					field_d = '0;
					has_digit_d = 1'b0;
					kept_d = '0;
					staged_d.bold = cbold_q;
					staged_d.color = ccolor_q;
					staged_d.color_set = 1'b0;
				end else begin
					mode_d = MODE_NORMAL;
				end
			end
			MODE_CSI: begin
				if (is_digit || byte_in == ascf_pkg::CH_SEMI) begin
					if (kept_q < ascf_pkg::KEPT_W'(ascf_pkg::MAX_PARAM_BYTES)) begin
						kept_d = kept_q + 1'b1;
						if (is_digit) begin
							field_d = (acc > 11'(ascf_pkg::FIELD_MAX)) ?
								ascf_pkg::FIELD_MAX : acc[ascf_pkg::FIELD_W-1:0];
							has_digit_d = 1'b1;
						end else begin
							staged_d = semi_stage;
							field_d = '0;
							has_digit_d = 1'b0;
						end
					end
				end else begin
					mode_d = MODE_NORMAL;
					if (byte_in == ascf_pkg::CH_M) begin
						staged_d = final_stage;
						cbold_d = final_stage.bold;
						if (final_stage.color_set) begin
							ccolor_d = final_stage.color;
						end
						res.valid = 1'b1;
						res.kind = ascf_pkg::KIND_COLOR;
						res.char_out = '0;
						res.color = final_stage.color_set ? final_stage.color : ccolor_q;
					end
				end
			end
			default: begin
				mode_d = MODE_NORMAL;
				if (byte_in == ascf_pkg::CH_ESC) begin
					mode_d = MODE_ESC;
				end else begin
					res.valid = 1'b1;
				end
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q <= MODE_NORMAL;
			field_q <= '0;
			has_digit_q <= 1'b0;
			kept_q <= '0;
			staged_q.bold <= 1'b0;
			staged_q.color <= ascf_pkg::COLOR_GREY;
			staged_q.color_set <= 1'b0;
			cbold_q <= 1'b0;
			ccolor_q <= ascf_pkg::COLOR_GREY;
		end else if (en) begin
			mode_q <= mode_d;
			field_q <= field_d;
			has_digit_q <= has_digit_d;
			kept_q <= kept_d;
			staged_q <= staged_d;
			cbold_q <= cbold_d;
			ccolor_q <= ccolor_d;
		end
	end

endmodule

### sv/ascf_out_reg.sv
`timescale 1ns / 1ps

module ascf_out_reg (
	input  logic clk,
	input  logic arst_n,
	input  logic load,
	input  ascf_pkg::ascf_res_t res,
	output logic free,
	output logic m_tvalid,
	input  logic m_tready,
	output logic [15:0] m_tdata,
	output logic [0:0] m_tuser
);

	logic valid_q;
	logic kind_q;
	logic [7:0] char_q;
	logic [3:0] color_q;

	// slot can take a new result when empty or being drained this cycle
	assign free = !valid_q || m_tready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (load) begin
			valid_q <= res.valid;
		end else if (m_tready) begin
			valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (load && res.valid) begin
			kind_q <= res.kind;
			char_q <= res.char_out;
			color_q <= res.color;
		end
	end

	assign m_tvalid = valid_q;
	assign m_tdata = {4'b0000, color_q, char_q};
	assign m_tuser = kind_q;

endmodule
